/* sv/fdt_pkg.sv */
// Shared types and constants for the flow drop table with expiry.
`timescale 1ns / 1ps

package fdt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int TTL_W  = 31;
    localparam int TIME_W = 32;
    localparam int PID_W  = 32;
    localparam int IP_W   = 32;
    localparam int PORT_W = 16;
    localparam int PROTO_W = 8;
    localparam int PP_W   = PORT_W + PROTO_W;

    localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(30000);

    // Operation codes of an input beat.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_NONE      = 2'd0;
    localparam logic [1:0] ST_REFRESHED = 2'd1;
    localparam logic [1:0] ST_INSERTED  = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // One slot of the table as held in memory.
    typedef struct packed {
        logic              valid;
        logic [PID_W-1:0]  pid;
        logic [IP_W-1:0]   ip;
        logic [PP_W-1:0]   pp;
        logic [TIME_W-1:0] expiry;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd_en;
        logic clr_wr;
        logic finish;
    } cmd_t;

endpackage

/* sv/flow_drop_table_with_ttl.sv */
// Top level of the flow drop table with expiry: register port, controller and datapath.
// An add or query beat scans every slot through one memory read port before the
// finish step registers its result; a tick or unused opcode goes straight to the
// finish step. The finish step waits while an earlier result has not been taken,
// and a new beat is taken only once the last one has finished.
// After reset a clearing pass marks every slot free; ready stays low until it ends.
`timescale 1ns / 1ps

module flow_drop_table_with_ttl #(
    parameter int TABLE_ENTRIES = fdt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // Input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_opcode,
    input  logic [fdt_pkg::PID_W-1:0]   s_flow_pid,
    input  logic [fdt_pkg::IP_W-1:0]    s_flow_ip,
    input  logic [fdt_pkg::PORT_W-1:0]  s_flow_port,
    input  logic [fdt_pkg::PROTO_W-1:0] s_flow_proto,
    // Result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_blocked,
    output logic [1:0]                  m_status
);
    import fdt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    // Register index is the word address; there is only the lifetime register.
    localparam logic REG_TTL = 1'b0;

    logic [TTL_W-1:0] ttl_reg;
    logic             cfg_wr;
    cmd_t             cmd;
    logic [IDX_W-1:0] idx;
    logic             out_free;

    // The port never inserts wait states. A write lands in the access cycle.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TTL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ttl_reg <= TTL_RESET;
        end else if (cfg_wr) begin
            ttl_reg <= pwdata[TTL_W-1:0];
        end
    end

    // Reads of addresses beyond the register list return zero.
    assign prdata = (paddr[2] == REG_TTL) ? {1'b0, ttl_reg} : 32'd0;

    // The controller steps through the clearing pass after reset, then for each beat
    // either scans every slot in address order or goes straight to the finish step.
    fdt_ctrl #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_opcode(s_opcode),
        .out_free(out_free),
        .s_ready (s_ready),
        .cmd     (cmd),
        .idx     (idx)
    );

    // The datapath judges each slot as it is read: an expired slot is freed on the spot,
    // the first live match and the first free slot are remembered, and the finish step
    // writes back the refreshed or inserted slot and loads the result register. The
    // result register lets the scan of the next beat run while a result waits.
    fdt_datapath #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .idx         (idx),
        .s_opcode    (s_opcode),
        .s_flow_pid  (s_flow_pid),
        .s_flow_ip   (s_flow_ip),
        .s_flow_port (s_flow_port),
        .s_flow_proto(s_flow_proto),
        .ttl_ticks   (ttl_reg),
        .out_free    (out_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_blocked   (m_blocked),
        .m_status    (m_status)
    );

`ifndef NO_ASSERTIONS
    // Only a query can report a block, and a query always reports no status.
    a_blocked_only_query: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_blocked) |-> (m_status == ST_NONE))
        else $error("blocked result carries a status");

    // One beat at a time: no beat is taken in the cycle after one was taken.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken on consecutive cycles");

    // The clearing pass holds off input right after reset.
    a_clear_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !s_ready)
        else $error("input ready during clearing pass");

    // A beat of a scanning operation cannot finish in the following cycle.
    a_scan_not_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_opcode == OP_ADD || s_opcode == OP_QUERY) && !m_valid)
        |=> !m_valid)
        else $error("scan result appeared too early");
`endif

endmodule

/* sv/fdt_ctrl.sv */
// Sequencing state machine for the flow drop table: clearing pass, scan and finish.
`timescale 1ns / 1ps

module fdt_ctrl #(
    parameter int TABLE_ENTRIES = fdt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic [1:0]                       s_opcode,
    input  logic                             out_free,
    output logic                             s_ready,
    output fdt_pkg::cmd_t                    cmd,
    output logic [$clog2(TABLE_ENTRIES)-1:0] idx
);
    import fdt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign idx     = cnt_reg[IDX_W-1:0];
    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    if (s_opcode == OP_ADD || s_opcode == OP_QUERY) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN: begin
                // The last slot is judged in the cycle after its read.
                if (cnt_reg == CNT_END) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.rd_en = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* sv/fdt_datapath.sv */
// Slot memory, tick counter, scan evaluation and result register of the flow drop table.
`timescale 1ns / 1ps

module fdt_datapath #(
    parameter int TABLE_ENTRIES = fdt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  fdt_pkg::cmd_t                    cmd,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] idx,
    input  logic [1:0]                       s_opcode,
    input  logic [fdt_pkg::PID_W-1:0]        s_flow_pid,
    input  logic [fdt_pkg::IP_W-1:0]         s_flow_ip,
    input  logic [fdt_pkg::PORT_W-1:0]       s_flow_port,
    input  logic [fdt_pkg::PROTO_W-1:0]      s_flow_proto,
    input  logic [fdt_pkg::TTL_W-1:0]        ttl_ticks,
    output logic                             out_free,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_blocked,
    output logic [1:0]                       m_status
);
    import fdt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    entry_t mem [TABLE_ENTRIES];
    entry_t rd_data_reg;

    logic              eval_vld_reg;
    logic [IDX_W-1:0]  eval_addr_reg;
    logic [1:0]        op_reg;
    logic [PID_W-1:0]  pid_reg;
    logic [IP_W-1:0]   ip_reg;
    logic [PP_W-1:0]   pp_reg;
    logic [TIME_W-1:0] now_reg;
    logic              hit_found_reg, free_found_reg;
    logic [IDX_W-1:0]  hit_idx_reg, free_idx_reg;
    logic              m_valid_reg, m_blocked_reg;
    logic [1:0]        m_status_reg;

    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] expiry_new;
    logic              expired, live, key_eq, purge;
    logic              fin_wr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    logic              blocked_res;
    logic [1:0]        status_res;

    // A slot is expired once now minus expiry, read as signed, is not negative.
    assign age        = now_reg - rd_data_reg.expiry;
    assign expired    = ~age[TIME_W-1];
    assign live       = rd_data_reg.valid & ~expired;
    assign key_eq     = (rd_data_reg.pid == pid_reg) && (rd_data_reg.ip == ip_reg) &&
                        (rd_data_reg.pp == pp_reg);
    assign purge      = eval_vld_reg & rd_data_reg.valid & expired;
    assign expiry_new = now_reg + {1'b0, ttl_ticks};

    assign fin_wr = cmd.finish && (op_reg == OP_ADD) && (hit_found_reg || free_found_reg);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx;
        wr_data = '0;
        if (cmd.clr_wr) begin
            wr_en = 1'b1;
        end else if (purge) begin
            wr_en         = 1'b1;
            wr_addr       = eval_addr_reg;
            wr_data       = rd_data_reg;
            wr_data.valid = 1'b0;
        end else if (fin_wr) begin
            wr_en          = 1'b1;
            wr_addr        = hit_found_reg ? hit_idx_reg : free_idx_reg;
            wr_data.valid  = 1'b1;
            wr_data.pid    = pid_reg;
            wr_data.ip     = ip_reg;
            wr_data.pp     = pp_reg;
            wr_data.expiry = expiry_new;
        end
    end

    always_comb begin
        blocked_res = 1'b0;
        status_res  = ST_NONE;
        case (op_reg)
            OP_ADD: begin
                if (hit_found_reg) begin
                    status_res = ST_REFRESHED;
                end else if (free_found_reg) begin
                    status_res = ST_INSERTED;
                end else begin
                    status_res = ST_FULL;
                end
            end
            OP_QUERY: begin
                blocked_res = hit_found_reg;
            end
            default: begin
                status_res = ST_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg <= mem[idx];
        end
    end

    always_ff @(posedge aclk) begin
        eval_addr_reg <= idx;
        if (cmd.load) begin
            op_reg  <= s_opcode;
            pid_reg <= s_flow_pid;
            ip_reg  <= s_flow_ip;
            pp_reg  <= {s_flow_port, s_flow_proto};
        end
        if (eval_vld_reg && live && key_eq && !hit_found_reg) begin
            hit_idx_reg <= eval_addr_reg;
        end
        if (eval_vld_reg && !live && !free_found_reg) begin
            free_idx_reg <= eval_addr_reg;
        end
        if (cmd.finish) begin
            m_blocked_reg <= blocked_res;
            m_status_reg  <= status_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eval_vld_reg   <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            now_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            eval_vld_reg <= cmd.rd_en;
            if (cmd.load) begin
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end else if (eval_vld_reg) begin
                if (live && key_eq) begin
                    hit_found_reg <= 1'b1;
                end
                if (!live) begin
                    free_found_reg <= 1'b1;
                end
            end
            if (cmd.finish && op_reg == OP_TICK) begin
                now_reg <= now_reg + 1'b1;
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_blocked = m_blocked_reg;
    assign m_status  = m_status_reg;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the flow drop table with expiry.
`timescale 1ns / 1ps

module tb;
    import fdt_pkg::*;

    localparam int SLOTS           = TABLE_ENTRIES_DEF;
    localparam int KEY_POOL        = 96;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 1_000_000;

    // Register map: the lifetime register is the only one and sits at byte address zero.
    localparam logic [2:0] TTL_ADDR = 3'd0;

    // The opcode field is two bits wide, so one code is left without a meaning.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [TTL_W-1:0] TTL_MAX = '1;

    // A flow key laid out so that comparing two keys compares pid, address, port and
    // protocol all at once, exactly as the block matches a slot.
    typedef struct packed {
        logic [PID_W-1:0]   pid;
        logic [IP_W-1:0]    ip;
        logic [PORT_W-1:0]  port;
        logic [PROTO_W-1:0] proto;
    } flow_key_t;

    localparam int KEY_BITS = $bits(flow_key_t);

    typedef struct packed {
        logic       blocked;
        logic [1:0] status;
    } verdict_t;

    // Holds a private copy of the table, the tick counter and the lifetime. Every
    // accepted input beat is applied to that copy at once and the verdict that it
    // must give is queued; result beats are then checked in order against the queue.
    class verdict_board;
        logic              slot_live [SLOTS];
        flow_key_t         slot_key [SLOTS];
        logic [TIME_W-1:0] slot_expiry [SLOTS];
        logic [TIME_W-1:0] now_ticks;
        logic [TTL_W-1:0]  ttl_ticks;
        verdict_t          pending_verdicts [$];
        int                errors;

        function new();
            foreach (slot_live[i]) slot_live[i] = 1'b0;
            now_ticks = '0;
            ttl_ticks = TTL_RESET;
            errors    = 0;
        endfunction

        function void note_beat(logic [1:0] op, flow_key_t key);
            verdict_t          v;
            logic [TIME_W-1:0] age;
            int                hit;
            v.blocked = 1'b0;
            v.status  = ST_NONE;
            hit       = -1;
            if (op == OP_TICK) begin
                now_ticks = now_ticks + 1'b1;
            end else if (op == OP_ADD || op == OP_QUERY) begin
                // Expired slots are freed before the lookup. The age is read as a
                // signed number so that the comparison survives the counter wrapping.
                for (int i = 0; i < SLOTS; i++) begin
                    age = now_ticks - slot_expiry[i];
                    if (slot_live[i] && !age[TIME_W-1]) slot_live[i] = 1'b0;
                end
                for (int i = 0; i < SLOTS; i++) begin
                    if (hit < 0 && slot_live[i] && slot_key[i] == key) hit = i;
                end
                if (op == OP_QUERY) begin
                    v.blocked = (hit >= 0);
                end else if (hit >= 0) begin
                    slot_expiry[hit] = now_ticks + TIME_W'(ttl_ticks);
                    v.status = ST_REFRESHED;
                end else begin
                    // The lowest free slot takes the key; with none free the add is lost.
                    v.status = ST_FULL;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (v.status == ST_FULL && !slot_live[i]) begin
                            slot_live[i]   = 1'b1;
                            slot_key[i]    = key;
                            slot_expiry[i] = now_ticks + TIME_W'(ttl_ticks);
                            v.status       = ST_INSERTED;
                        end
                    end
                end
            end
            pending_verdicts.push_back(v);
        endfunction

        function void check_verdict(logic blocked, logic [1:0] status);
            verdict_t want;
            if (pending_verdicts.size() == 0) begin
                errors++;
                $display("%0t: result beat with none pending: blocked %0b status %0d",
                         $time, blocked, status);
                return;
            end
            want = pending_verdicts.pop_front();
            if (blocked !== want.blocked) begin
                errors++;
                $display("%0t: blocked mismatch: expected %0b, actual %0b",
                         $time, want.blocked, blocked);
            end
            if (status !== want.status) begin
                errors++;
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, status);
            end
        endfunction

        function int outstanding();
            return pending_verdicts.size();
        endfunction
    endclass

    // Every input of the block holds a known value from time zero.
    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [2:0]          paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [1:0]          s_opcode     = OP_TICK;
    logic [PID_W-1:0]    s_flow_pid   = '0;
    logic [IP_W-1:0]     s_flow_ip    = '0;
    logic [PORT_W-1:0]   s_flow_port  = '0;
    logic [PROTO_W-1:0]  s_flow_proto = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_blocked;
    logic [1:0]          m_status;

    verdict_board board;
    flow_key_t    key_pool [KEY_POOL];
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    int           hold_left      = 0;
    int           cycle_count;

    flow_drop_table_with_ttl #(
        .TABLE_ENTRIES (SLOTS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_flow_pid   (s_flow_pid),
        .s_flow_ip    (s_flow_ip),
        .s_flow_port  (s_flow_port),
        .s_flow_proto (s_flow_proto),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_blocked    (m_blocked),
        .m_status     (m_status)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Result side. The receiver either honours a hold-off set by the stimulus, during
    // which it refuses every beat, or stalls at random at the rate of the current phase.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Result beats are sampled at the edge that accepts them, so the values seen are
    // those that stood before the edge whatever order the processes run in.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_verdict(m_blocked, m_status);
    end

    // Guards against a hung block: the run is abandoned once the cycle count is spent.
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge aclk);
        $display("%0t: cycle limit reached with %0d results outstanding",
                 $time, board.outstanding());
        $display("tb: errors");
        $finish;
    end

    function automatic flow_key_t random_key();
        flow_key_t k;
        k.pid   = $urandom;
        k.ip    = $urandom;
        k.port  = PORT_W'($urandom);
        k.proto = PROTO_W'($urandom);
        return k;
    endfunction

    // Offers one beat and returns at the edge that accepts it, with valid still high.
    // It is always entered just after the clock rises. When an idle gap is drawn, valid is
    // dropped in that time step and raised again only at a later edge, so a signal never
    // takes competing nonblocking assignments in the same time step.
    task automatic send_flow(input logic [1:0] op, input flow_key_t key);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_flow_pid   <= key.pid;
        s_flow_ip    <= key.ip;
        s_flow_port  <= key.port;
        s_flow_proto <= key.proto;
        do @(posedge aclk); while (!s_ready);
        board.note_beat(op, key);
    endtask

    // Stops offering beats and waits until every queued verdict has been checked.
    task automatic wait_for_verdicts();
        s_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge aclk);
    endtask

    // Writes the lifetime register through the register port and reads it back. The
    // block must be idle when this is called.
    task automatic set_lifetime(input logic [TTL_W-1:0] ticks);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TTL_ADDR;
        pwdata  <= 32'(ticks);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        board.ttl_ticks = ticks;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[TTL_W-1:0] !== ticks) begin
            board.errors++;
            $display("%0t: lifetime read back mismatch: expected %0d, actual %0d",
                     $time, ticks, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One phase of random traffic. The lifetime and the idle rates are set first, with
    // the block drained. Adds and queries draw their keys from the first pool_n keys of
    // the pool so that hits, refreshes and expiries are common; ticks and unused
    // opcodes carry fully random fields. With walk set, adds step through the whole
    // pool in order, which fills the table and then runs into the full case.
    task automatic run_phase(input logic [TTL_W-1:0] lifetime, input int idle_pct,
                             input int stall_pct, input int beats, input int pool_n,
                             input int w_tick, input int w_add, input int w_query,
                             input bit walk, input bit hold);
        int         pick;
        int         walk_pos;
        logic [1:0] op;
        flow_key_t  key;
        walk_pos = 0;
        wait_for_verdicts();
        set_lifetime(lifetime);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        // A long hold-off lets the sender keep offering beats until the block's
        // result register is full and input ready falls.
        if (hold) hold_left = HOLD_OFF_CYCLES;
        for (int n = 0; n < beats; n++) begin
            pick = $urandom_range(99);
            if (pick < w_tick)                        op = OP_TICK;
            else if (pick < w_tick + w_add)           op = OP_ADD;
            else if (pick < w_tick + w_add + w_query) op = OP_QUERY;
            else                                      op = OP_UNUSED;
            if (op == OP_ADD && walk) begin
                key = key_pool[walk_pos % KEY_POOL];
                walk_pos++;
            end else if (op == OP_ADD || op == OP_QUERY) begin
                key = key_pool[$urandom_range(pool_n - 1)];
            end else begin
                key = random_key();
            end
            send_flow(op, key);
        end
    endtask

    initial begin
        flow_key_t k;
        board = new();

        // Roughly half of the pool are near misses: a copy of the previous key with
        // one bit flipped, so that every field of the match is exercised.
        for (int i = 0; i < KEY_POOL; i++) begin
            if (i > 0 && $urandom_range(1) == 0) begin
                key_pool[i] = key_pool[i - 1];
                key_pool[i][$urandom_range(KEY_BITS - 1)] ^= 1'b1;
            end else begin
                key_pool[i] = random_key();
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed beats, first with the lifetime still at its reset value. The block
        // runs its clearing pass first; the sender simply waits for ready.
        send_flow(OP_QUERY, '0);     // query on an empty table
        send_flow(OP_ADD, '0);       // all-zero key inserted
        send_flow(OP_ADD, '0);       // and refreshed
        send_flow(OP_QUERY, '0);     // live match blocks
        send_flow(OP_ADD, '1);       // all-ones key
        send_flow(OP_QUERY, '1);
        k = '1;
        k.proto[0] = 1'b0;
        send_flow(OP_QUERY, k);      // differs in one protocol bit only
        k = '1;
        k.port = '0;
        send_flow(OP_ADD, k);        // same pid and address, other port: a new key
        send_flow(OP_QUERY, k);
        send_flow(OP_TICK, '1);      // a tick gives an empty verdict whatever its fields
        send_flow(OP_UNUSED, '1);    // the spare opcode changes nothing
        send_flow(OP_UNUSED, '0);

        // Zero lifetime: the entry goes in but is already expired at the same tick.
        wait_for_verdicts();
        set_lifetime('0);
        k = key_pool[1];
        send_flow(OP_ADD, k);
        send_flow(OP_QUERY, k);
        send_flow(OP_ADD, k);

        // Short lifetime: the entry blocks for one tick and has gone after the next.
        wait_for_verdicts();
        set_lifetime(TTL_W'(2));
        send_flow(OP_ADD, k);
        send_flow(OP_TICK, k);
        send_flow(OP_QUERY, k);
        send_flow(OP_TICK, k);
        send_flow(OP_QUERY, k);
        send_flow(OP_ADD, '0);       // the all-zero key is still live and is refreshed

        // Random phases. Each starts with the sender paused until all verdicts are in.
        // The phase with the largest lifetime comes last, since its entries never expire
        // within the run and would keep the table full for any phase after it.
        run_phase(TTL_RESET, 0, 0, 160, 24, 10, 45, 40, 1'b0, 1'b0);
        run_phase('0, 0, 60, 130, 24, 15, 45, 35, 1'b0, 1'b0);
        run_phase(TTL_W'(6), 28, 28, 200, 48, 40, 30, 27, 1'b0, 1'b0);
        run_phase(TTL_W'(1), 60, 0, 140, 48, 35, 35, 27, 1'b0, 1'b1);
        run_phase(TTL_MAX, 0, 0, 200, KEY_POOL, 5, 70, 24, 1'b1, 1'b0);

        // Drain, then let the clock run on so that any stray result beat is caught.
        wait_for_verdicts();
        repeat (SLOTS + 8) @(posedge aclk);
        if (board.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

/* files.f */
sv/fdt_pkg.sv
sv/fdt_ctrl.sv
sv/fdt_datapath.sv
sv/flow_drop_table_with_ttl.sv
tb/tb.sv
